// ===== rtl/bha_pkg.sv =====
// Shared types, codes and defaults for the bitmap handle allocator.
`default_nettype none

package bha_pkg;

  localparam int HANDLES_DEF   = 256;
  localparam int WORD_BITS_DEF = 32;

  localparam int SIZE_W   = 9;
  localparam int HANDLE_W = 8;
  localparam int ITEM_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // register map, word index on paddr
  localparam logic REG_HANDLES_IN_USE = 1'b0;
  localparam logic [SIZE_W-1:0] HANDLES_IN_USE_RST = 9'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_GET   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NOFREE     = 2'd1,
    STAT_BAD_HANDLE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_CHECK,
    S_FIN_ALLOC,
    S_FIN_NOFREE,
    S_FIN_ERR,
    S_FIN_FREE,
    S_FIN_GET
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    scan_clr;
    logic    scan_inc;
    logic    clear_wr;
    logic    cap_avail;
    logic    map_wr_alloc;
    logic    map_wr_free;
    logic    item_wr;
    logic    out_load;
    status_t out_status;
    logic    out_grant;
    logic    out_item;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              avail_nz;
    logic              last_word;
    logic              held;
    logic              out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/bha_ctrl.sv =====
// Controller state machine: clearing pass, request dispatch, map scan, result hand-off.
`default_nettype none

module bha_ctrl
  import bha_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_CLEAR: begin
        if (st.last_word) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_FETCH;
      end
      S_FETCH: begin
        unique case (st.mode) inside
          MODE_ALLOC: state_next = S_SCAN;
          MODE_FREE,
          MODE_GET:   state_next = S_CHECK;
          default:    state_next = S_FIN_ERR;
        endcase
      end
      S_SCAN: begin
        if (st.avail_nz) state_next = S_FIN_ALLOC;
        else if (st.last_word) state_next = S_FIN_NOFREE;
      end
      S_CHECK: begin
        if (!st.held) state_next = S_FIN_ERR;
        else if (st.mode == MODE_FREE) state_next = S_FIN_FREE;
        else state_next = S_FIN_GET;
      end
      S_FIN_ALLOC,
      S_FIN_NOFREE,
      S_FIN_ERR,
      S_FIN_FREE,
      S_FIN_GET: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.last_word) cmd.scan_clr = 1'b1;
        else cmd.scan_inc = 1'b1;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in  = 1'b1;
          cmd.scan_clr = 1'b1;
        end
      end
      S_FETCH: begin
      end
      S_SCAN: begin
        if (st.avail_nz) cmd.cap_avail = 1'b1;
        else if (!st.last_word) cmd.scan_inc = 1'b1;
      end
      S_CHECK: begin
      end
      S_FIN_ALLOC: begin
        if (st.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_status   = STAT_OK;
          cmd.out_grant    = 1'b1;
          cmd.map_wr_alloc = 1'b1;
          cmd.item_wr      = 1'b1;
        end
      end
      S_FIN_NOFREE: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = STAT_NOFREE;
        end
      end
      S_FIN_ERR: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = STAT_BAD_HANDLE;
        end
      end
      S_FIN_FREE: begin
        if (st.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = STAT_OK;
          cmd.map_wr_free = 1'b1;
        end
      end
      S_FIN_GET: begin
        if (st.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = STAT_OK;
          cmd.out_item   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bha_datapath.sv =====
// Datapath: free map and item memories, scan mask, top-bit encoder, output register.
`default_nettype none

module bha_datapath
  import bha_pkg::*;
#(
  parameter int HANDLES   = HANDLES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF   // power of two
)(
  input  wire                  clk,
  input  wire                  rst,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  wire [MODE_W-1:0]     in_mode,
  input  wire [ITEM_W-1:0]     in_item,
  input  wire [HANDLE_W-1:0]   in_handle,
  input  wire [SIZE_W-1:0]     size,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [HANDLE_W-1:0]  out_handle,
  output logic [ITEM_W-1:0]    out_item
);

  localparam int MAP_WORDS = (HANDLES + WORD_BITS - 1) / WORD_BITS;
  localparam int MAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LOGWB     = $clog2(WORD_BITS);
  localparam int HIW       = $clog2(HANDLES);
  localparam int CMPW      = (HIW + 1 > SIZE_W) ? HIW + 1 : SIZE_W;
  localparam logic [MAW-1:0]  LAST_WORD = MAW'(MAP_WORDS - 1);
  localparam logic [CMPW-1:0] HANDLES_C = CMPW'(HANDLES);
  localparam logic [CMPW-1:0] WB_C      = CMPW'(WORD_BITS);

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [ITEM_W-1:0]    item_mem [HANDLES];

  logic [MODE_W-1:0]    mode_q;
  logic [ITEM_W-1:0]    item_q;
  logic [HANDLE_W-1:0]  hin_q;
  logic [MAW-1:0]       scan_word;
  logic [WORD_BITS-1:0] map_rd_q;
  logic [WORD_BITS-1:0] avail_q;
  logic [ITEM_W-1:0]    item_rd_q;

  logic [CMPW-1:0]      size_x, size_eff, h_x, base_x, diff, grant;
  logic [MAW-1:0]       h_word, scan_next, map_raddr;
  logic [LOGWB-1:0]     h_bit, pos;
  logic [HIW-1:0]       h_idx;
  logic [WORD_BITS-1:0] vmask, avail, v, grant_mask, h_mask;

  // valid handle window and request handle decode
  always_comb begin
    size_x   = CMPW'(size);
    size_eff = (size_x > HANDLES_C) ? HANDLES_C : size_x;
    h_x      = CMPW'(hin_q);
    h_word   = MAW'(h_x >> LOGWB);
    h_bit    = h_x[LOGWB-1:0];
    h_idx    = h_x[HIW-1:0];
    h_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << h_bit;
  end

  // bits of the current scan word that lie below the size
  always_comb begin
    base_x = CMPW'(scan_word) << LOGWB;
    diff   = size_eff - base_x;
    if (size_eff <= base_x) vmask = '0;
    else if (diff >= WB_C) vmask = '1;
    else vmask = ~({WORD_BITS{1'b1}} << diff[LOGWB-1:0]);
    avail = map_rd_q & vmask;
  end

  // highest set bit of the captured word, binary search
  always_comb begin
    v   = avail_q;
    pos = '0;
    for (int s = LOGWB - 1; s >= 0; s--) begin
      if ((v >> (1 << s)) != '0) begin
        pos[s] = 1'b1;
        v      = v >> (1 << s);
      end
    end
    grant_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;
    grant      = (CMPW'(scan_word) << LOGWB) | CMPW'(pos);
  end

  always_comb begin
    scan_next = scan_word + MAW'(1);
    if (mode_q == MODE_ALLOC) map_raddr = cmd.scan_inc ? scan_next : scan_word;
    else map_raddr = h_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_word <= '0;
    end else if (cmd.scan_clr) begin
      scan_word <= '0;
    end else if (cmd.scan_inc) begin
      scan_word <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q <= in_mode;
      item_q <= in_item;
      hin_q  <= in_handle;
    end
    if (cmd.cap_avail) avail_q <= avail;
  end

  // free map, one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      map_mem[scan_word] <= '1;
    end else if (cmd.map_wr_alloc) begin
      map_mem[scan_word] <= map_rd_q & ~grant_mask;
    end else if (cmd.map_wr_free) begin
      map_mem[h_word] <= map_rd_q | h_mask;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.item_wr) item_mem[grant[HIW-1:0]] <= item_q;
    item_rd_q <= item_mem[h_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_handle <= cmd.out_grant ? grant[HANDLE_W-1:0] : '0;
      out_item   <= cmd.out_item ? item_rd_q : '0;
    end
  end

  always_comb begin
    st.mode      = mode_q;
    st.avail_nz  = |avail;
    st.last_word = (scan_word == LAST_WORD);
    st.held      = (h_x < size_eff) && !map_rd_q[h_bit];
    st.out_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_handle_allocator_top.sv =====
// Top level of the bitmap handle allocator: stream ports, register port, controller and datapath.
//
// Requests come in on the s_axis channel, one word at a time: tuser carries the
// request kind (allocate, free, get), tdata the item word and the handle. Each
// request gives exactly one result word on m_axis: tuser is the status, tdata the
// granted handle and the stored item (zero where they do not apply).
// Requests are handled one at a time. Allocate goes from acceptance through a fetch
// state and a scan of W map words (1 to HANDLES/WORD_BITS, 8 by default) to the
// result register; the scan reads one free-map word per cycle from a memory with
// a registered read port. Free and get pass through a fetch and a check state, an
// undefined kind goes from fetch straight to its result. The next request can be
// accepted in the cycle after the result is loaded. The result sits in an output
// register; a stalled receiver holds it there, and the block takes one more request
// but does not finish it until that word leaves. After reset the free map is set to
// all free in a pass over the HANDLES/WORD_BITS map words (8 by default) during
// which s_axis_tready stays low; register writes are taken throughout.
// handles_in_use lies at address 0 and resets to 256.
`default_nettype none

module bitmap_handle_allocator_top
  import bha_pkg::*;
#(
  parameter int HANDLES   = HANDLES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
)(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,    // item_value[31:0], handle_in[39:32]
  input  wire  [1:0]  s_axis_tuser,    // mode[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,    // handle_out[7:0], item_out[39:8]
  output logic [1:0]  m_axis_tuser,    // status[1:0]
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t  cmd;
  stat_t st;

  logic [SIZE_W-1:0]   handles_in_use;
  logic [HANDLE_W-1:0] out_handle;
  logic [ITEM_W-1:0]   out_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      handles_in_use <= HANDLES_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_HANDLES_IN_USE) begin
      handles_in_use <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_HANDLES_IN_USE) prdata = {{(32-SIZE_W){1'b0}}, handles_in_use};
  end

  bha_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  bha_datapath #(
    .HANDLES   (HANDLES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (s_axis_tuser),
    .in_item    (s_axis_tdata[31:0]),
    .in_handle  (s_axis_tdata[39:32]),
    .size       (handles_in_use),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_handle (out_handle),
    .out_item   (out_item)
  );

  assign m_axis_tdata = {out_item, out_handle};

endmodule

`default_nettype wire

// ===== rtl/bha_checker.sv =====
// Port-level checks for the bitmap handle allocator, bound to the top level.
`default_nettype none

module bha_checker
  import bha_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // one request at a time: after an accept, s_axis_tready drops
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_NOFREE ||
                       m_axis_tuser == STAT_BAD_HANDLE))
    else $error("undefined status code");

  // failures carry no handle and no item; success carries at most one of them
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
    else $error("failed request returned data");

  a_one_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == '0 || m_axis_tdata[39:8] == '0))
    else $error("both handle and item nonzero");

endmodule

bind bitmap_handle_allocator_top bha_checker u_bha_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
